[sv/stt_pkg.sv]
// Shared types, character codes and token codes for the source text tokenizer.
// Holds the keyword spelling tables and character class helpers.
// No dependencies.
package stt_pkg;

  localparam int MaxResults = 7;
  localparam int ResCntW    = 3;

  typedef logic [5:0] tok_t;
  typedef logic [ResCntW-1:0] res_cnt_t;

  // Result kinds
  localparam logic ResText = 1'b0;
  localparam logic ResEnd  = 1'b1;

  // Token types
  localparam tok_t TokWord    = 6'd0;
  localparam tok_t TokString  = 6'd1;
  localparam tok_t TokSemi    = 6'd2;
  localparam tok_t TokLBrace  = 6'd3;
  localparam tok_t TokRBrace  = 6'd4;
  localparam tok_t TokLParen  = 6'd5;
  localparam tok_t TokRParen  = 6'd6;
  localparam tok_t TokDot     = 6'd7;
  localparam tok_t TokComma   = 6'd8;
  localparam tok_t TokPlus    = 6'd9;
  localparam tok_t TokMinus   = 6'd10;
  localparam tok_t TokStar    = 6'd11;
  localparam tok_t TokSlash   = 6'd12;
  localparam tok_t TokEqual   = 6'd13;
  localparam tok_t TokExcl    = 6'd14;
  localparam tok_t TokPlusEq  = 6'd15;
  localparam tok_t TokMinusEq = 6'd16;
  localparam tok_t TokStarEq  = 6'd17;
  localparam tok_t TokSlashEq = 6'd18;
  localparam tok_t TokEqEq    = 6'd19;
  localparam tok_t TokNotEq   = 6'd20;
  localparam tok_t TokIncr    = 6'd21;
  localparam tok_t TokDecr    = 6'd22;
  localparam tok_t TokLt      = 6'd23;
  localparam tok_t TokGt      = 6'd24;
  localparam tok_t TokLe      = 6'd25;
  localparam tok_t TokGe      = 6'd26;
  localparam tok_t TokLArrow  = 6'd27;
  localparam tok_t TokRArrow  = 6'd28;
  localparam tok_t TokKwBase  = 6'd29;
  localparam tok_t TokNone    = 6'd63;

  // Character codes
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharExcl   = 8'h21;
  localparam logic [7:0] CharLParen = 8'h28;
  localparam logic [7:0] CharRParen = 8'h29;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharSemi   = 8'h3B;
  localparam logic [7:0] CharLt     = 8'h3C;
  localparam logic [7:0] CharEq     = 8'h3D;
  localparam logic [7:0] CharGt     = 8'h3E;
  localparam logic [7:0] CharLBrace = 8'h7B;
  localparam logic [7:0] CharRBrace = 8'h7D;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;

  typedef struct packed {
    logic       kind;
    tok_t       ttype;
    logic [7:0] ch;
  } stt_res_t;

  typedef stt_res_t [MaxResults-1:0] res_vec_t;

  // Keyword lengths: for, while, if, else
  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] len;
    case (k)
      2'd0:    len = 3'd3;
      2'd1:    len = 3'd5;
      2'd2:    len = 3'd2;
      default: len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          3'd0:    ch = "f";
          3'd1:    ch = "o";
          3'd2:    ch = "r";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0:    ch = "w";
          3'd1:    ch = "h";
          3'd2:    ch = "i";
          3'd3:    ch = "l";
          3'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0:    ch = "i";
          3'd1:    ch = "f";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    ch = "e";
          3'd1:    ch = "l";
          3'd2:    ch = "s";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c inside {CharSpace, [CharTab:CharCr]});
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c inside {CharPlus, CharMinus, CharStar, CharSlash,
                      CharEq, CharExcl, CharLt, CharGt});
  endfunction

  // Punctuation token type, TokNone when c is not punctuation
  function automatic tok_t punct_code(input logic [7:0] c);
    tok_t t;
    case (c)
      CharSemi:   t = TokSemi;
      CharLBrace: t = TokLBrace;
      CharRBrace: t = TokRBrace;
      CharLParen: t = TokLParen;
      CharRParen: t = TokRParen;
      CharDot:    t = TokDot;
      CharComma:  t = TokComma;
      default:    t = TokNone;
    endcase
    return t;
  endfunction

  // Single-character operator kind; '<' is the fallback
  function automatic tok_t oper_kind(input logic [7:0] c);
    tok_t t;
    case (c)
      CharPlus:  t = TokPlus;
      CharMinus: t = TokMinus;
      CharStar:  t = TokStar;
      CharSlash: t = TokSlash;
      CharEq:    t = TokEqual;
      CharExcl:  t = TokExcl;
      CharGt:    t = TokGt;
      default:   t = TokLt;
    endcase
    return t;
  endfunction

endpackage

[sv/stt_lexer.sv]
// Tokenizer state registers and single-pass result generation for one character.
// Produces the full result list of the registered character combinationally.
// Depends on stt_pkg.
module stt_lexer #(
  parameter int KEYWORD_HOLD = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic [7:0]          char_i,
  input  logic                eot_i,
  output stt_pkg::res_vec_t   res_o,
  output stt_pkg::res_cnt_t   res_cnt_o
);

  localparam int IdxW = $clog2(KEYWORD_HOLD);

  typedef logic [KEYWORD_HOLD-1:0][7:0] held_t;

  stt_pkg::tok_t open_q, open_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [3:0]    km_q, km_d;
  held_t         held_q, held_d;

  stt_pkg::res_vec_t res;
  stt_pkg::res_cnt_t n;

  function automatic void emit(inout stt_pkg::res_vec_t rv, inout stt_pkg::res_cnt_t rn,
                               input logic kind, input stt_pkg::tok_t tt,
                               input logic [7:0] ch);
    if (rn < stt_pkg::res_cnt_t'(stt_pkg::MaxResults)) begin
      rv[rn].kind  = kind;
      rv[rn].ttype = tt;
      rv[rn].ch    = ch;
      rn           = rn + 1'b1;
    end
  endfunction

  function automatic void flush(inout stt_pkg::res_vec_t rv, inout stt_pkg::res_cnt_t rn,
                                inout logic [2:0] cnt, input held_t held);
    for (int i = 0; i < KEYWORD_HOLD; i++) begin
      if (i < int'(cnt)) begin
        emit(rv, rn, stt_pkg::ResText, stt_pkg::TokWord, held[IdxW'(i)]);
      end
    end
    cnt = 3'd0;
  endfunction

  function automatic void close_tok(inout stt_pkg::res_vec_t rv, inout stt_pkg::res_cnt_t rn,
                                    inout stt_pkg::tok_t open, inout logic [2:0] cnt,
                                    inout logic [3:0] km, input held_t held);
    logic       found;
    logic [1:0] kw;
    found = 1'b0;
    kw    = 2'd0;
    if (open == stt_pkg::TokWord) begin
      for (int k = 0; k < 4; k++) begin
        if (km[k] && cnt == stt_pkg::kw_len(2'(k))) begin
          found = 1'b1;
          kw    = 2'(k);
        end
      end
      if (found) begin
        emit(rv, rn, stt_pkg::ResEnd, stt_pkg::TokKwBase + {4'd0, kw}, 8'h00);
      end else begin
        flush(rv, rn, cnt, held);
        emit(rv, rn, stt_pkg::ResEnd, stt_pkg::TokWord, 8'h00);
      end
    end else if (open != stt_pkg::TokNone) begin
      emit(rv, rn, stt_pkg::ResEnd, open, 8'h00);
    end
    open = stt_pkg::TokNone;
    cnt  = 3'd0;
    km   = 4'd0;
  endfunction

  // Hold a word character while it can still spell a keyword
  function automatic void word_char(inout stt_pkg::res_vec_t rv, inout stt_pkg::res_cnt_t rn,
                                    inout logic [2:0] cnt, inout logic [3:0] km,
                                    inout held_t held, input logic [7:0] c);
    logic [3:0] nm;
    nm = 4'd0;
    if (km == 4'd0) begin
      emit(rv, rn, stt_pkg::ResText, stt_pkg::TokWord, c);
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (km[k] && cnt < stt_pkg::kw_len(2'(k)) && stt_pkg::kw_char(2'(k), cnt) == c) begin
          nm[k] = 1'b1;
        end
      end
      if (nm != 4'd0 && int'(cnt) < KEYWORD_HOLD) begin
        held[cnt[IdxW-1:0]] = c;
        cnt = cnt + 3'd1;
        km  = nm;
      end else begin
        flush(rv, rn, cnt, held);
        emit(rv, rn, stt_pkg::ResText, stt_pkg::TokWord, c);
        km = 4'd0;
      end
    end
  endfunction

  function automatic void oper_char(inout stt_pkg::res_vec_t rv, inout stt_pkg::res_cnt_t rn,
                                    inout stt_pkg::tok_t open, inout logic [2:0] cnt,
                                    inout logic [3:0] km, input held_t held,
                                    input logic [7:0] c);
    stt_pkg::tok_t pair;
    pair = stt_pkg::TokNone;
    case (c)
      stt_pkg::CharEq: begin
        case (open)
          stt_pkg::TokPlus:  pair = stt_pkg::TokPlusEq;
          stt_pkg::TokMinus: pair = stt_pkg::TokMinusEq;
          stt_pkg::TokStar:  pair = stt_pkg::TokStarEq;
          stt_pkg::TokSlash: pair = stt_pkg::TokSlashEq;
          stt_pkg::TokEqual: pair = stt_pkg::TokEqEq;
          stt_pkg::TokExcl:  pair = stt_pkg::TokNotEq;
          stt_pkg::TokLt:    pair = stt_pkg::TokLe;
          stt_pkg::TokGt:    pair = stt_pkg::TokGe;
          default:           pair = stt_pkg::TokNone;
        endcase
      end
      stt_pkg::CharPlus: begin
        if (open == stt_pkg::TokPlus) pair = stt_pkg::TokIncr;
      end
      stt_pkg::CharMinus: begin
        if (open == stt_pkg::TokMinus) pair = stt_pkg::TokDecr;
        else if (open == stt_pkg::TokLt) pair = stt_pkg::TokLArrow;
      end
      stt_pkg::CharGt: begin
        if (open == stt_pkg::TokMinus) pair = stt_pkg::TokRArrow;
      end
      default: pair = stt_pkg::TokNone;
    endcase
    if (pair != stt_pkg::TokNone) begin
      emit(rv, rn, stt_pkg::ResEnd, pair, 8'h00);
      open = stt_pkg::TokNone;
    end else begin
      close_tok(rv, rn, open, cnt, km, held);
      open = stt_pkg::oper_kind(c);
    end
  endfunction

  always_comb begin
    stt_pkg::tok_t pc;
    res    = '0;
    n      = '0;
    open_d = open_q;
    cnt_d  = cnt_q;
    km_d   = km_q;
    held_d = held_q;
    pc     = stt_pkg::punct_code(char_i);
    if (char_i == stt_pkg::CharQuote) begin
      if (open_d != stt_pkg::TokString) begin
        close_tok(res, n, open_d, cnt_d, km_d, held_d);
        open_d = stt_pkg::TokString;
        emit(res, n, stt_pkg::ResText, stt_pkg::TokString, char_i);
      end else begin
        emit(res, n, stt_pkg::ResText, stt_pkg::TokString, char_i);
        close_tok(res, n, open_d, cnt_d, km_d, held_d);
      end
    end else if (open_d == stt_pkg::TokString) begin
      emit(res, n, stt_pkg::ResText, stt_pkg::TokString, char_i);
    end else if (stt_pkg::is_space(char_i)) begin
      close_tok(res, n, open_d, cnt_d, km_d, held_d);
    end else if (stt_pkg::is_oper(char_i)) begin
      oper_char(res, n, open_d, cnt_d, km_d, held_d, char_i);
    end else if (pc != stt_pkg::TokNone) begin
      close_tok(res, n, open_d, cnt_d, km_d, held_d);
      emit(res, n, stt_pkg::ResEnd, pc, 8'h00);
    end else if (open_d == stt_pkg::TokWord) begin
      word_char(res, n, cnt_d, km_d, held_d, char_i);
    end else begin
      // fresh word: every keyword still possible
      close_tok(res, n, open_d, cnt_d, km_d, held_d);
      open_d = stt_pkg::TokWord;
      cnt_d  = 3'd0;
      km_d   = 4'hF;
      word_char(res, n, cnt_d, km_d, held_d, char_i);
    end
    if (eot_i) begin
      close_tok(res, n, open_d, cnt_d, km_d, held_d);
    end
  end

  assign res_o     = res;
  assign res_cnt_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= stt_pkg::TokNone;
      cnt_q  <= 3'd0;
      km_q   <= 4'd0;
    end else if (adv_i) begin
      open_q <= open_d;
      cnt_q  <= cnt_d;
      km_q   <= km_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      held_q <= held_d;
    end
  end

endmodule

[sv/stt_out_buf.sv]
// Result buffer: loads one character's result list and shifts it out one per transaction.
// Flags the last result of each list.
// Depends on stt_pkg.
module stt_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  stt_pkg::res_vec_t res_i,
  input  stt_pkg::res_cnt_t res_cnt_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              stall_i,
  output logic              kind_o,
  output stt_pkg::tok_t     ttype_o,
  output logic [7:0]        ch_o,
  output logic              last_o
);

  stt_pkg::res_vec_t buf_q, buf_d;
  stt_pkg::res_cnt_t rem_q, rem_d;
  logic              pop;

  assign valid_o = (rem_q != '0);
  assign pop     = valid_o && !stall_i;
  assign free_o  = (rem_q == '0) || (rem_q == stt_pkg::res_cnt_t'(1) && pop);

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    if (load_i) begin
      buf_d = res_i;
      rem_d = res_cnt_i;
    end else if (pop) begin
      for (int i = 0; i < stt_pkg::MaxResults - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      buf_d[stt_pkg::MaxResults-1] = '0;
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign kind_o  = buf_q[0].kind;
  assign ttype_o = buf_q[0].ttype;
  assign ch_o    = buf_q[0].ch;
  assign last_o  = (rem_q == stt_pkg::res_cnt_t'(1));

endmodule

[sv/source_text_tokenizer.sv]
// Source text tokenizer top level: input register, lexer state/logic, result buffer.
// A character's results go from the input register into the result buffer register.
// Throughput: one character per cycle while each causes at most one result and the
// receiver does not stall; a character causing N results (up to 7) holds off the
// next character until the single result port of the output buffer has sent them.
// Reset: no token open, no held characters, input and output registers empty.
module source_text_tokenizer #(
  parameter int KEYWORD_HOLD = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    text_char_i,
  input  logic          end_of_text_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          result_kind_o,
  output logic [5:0]    token_type_o,
  output logic [7:0]    token_char_o,
  output logic          last_of_run_o
);

  logic              in_valid_q;
  logic [7:0]        char_q;
  logic              eot_q;
  logic              free;
  logic              adv;
  logic              accept;
  stt_pkg::res_vec_t res;
  stt_pkg::res_cnt_t res_cnt;

  assign adv        = in_valid_q && free;
  assign in_stall_o = in_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= text_char_i;
      eot_q  <= end_of_text_i;
    end
  end

  stt_lexer #(
    .KEYWORD_HOLD(KEYWORD_HOLD)
  ) u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .char_i   (char_q),
    .eot_i    (eot_q),
    .res_o    (res),
    .res_cnt_o(res_cnt)
  );

  stt_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv),
    .res_i    (res),
    .res_cnt_i(res_cnt),
    .free_o   (free),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .kind_o   (result_kind_o),
    .ttype_o  (token_type_o),
    .ch_o     (token_char_o),
    .last_o   (last_of_run_o)
  );

endmodule

[tb/tb_source_text_tokenizer.sv]
// Self-checking testbench for source_text_tokenizer: directed table, then random token streams.
// Predicts results with its own lexer model and checks each result transaction in order.
// Depends on stt_pkg (sv/stt_pkg.sv) and the source_text_tokenizer RTL.
module tb_source_text_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod = 12;
  localparam int HoldDepth = 5;
  localparam int NumRandom = 220;
  localparam int TimeoutNs = 2_400_000;

  // Keyword spellings and lengths, index 0..3 = for, while, if, else
  localparam logic [3:0][39:0] KwText = {{"else", 8'h00}, {"if", 24'h0}, "while", {"for", 16'h0}};
  localparam logic [3:0][2:0]  KwLen  = {3'd4, 3'd2, 3'd5, 3'd3};

  localparam logic [63:0] OpFirst  = "+-*/=!<>";
  localparam logic [31:0] OpSecond = "=+->";
  localparam logic [55:0] PunctSet = ";{}().,";
  localparam logic [47:0] SpaceSet = {stt_pkg::CharSpace, stt_pkg::CharTab, 8'h0A, 8'h0B, 8'h0C,
                                      stt_pkg::CharCr};

  typedef struct packed {
    logic          kind;
    stt_pkg::tok_t ttype;
    logic [7:0]    ch;
    logic          last;
  } tok_res_t;

  // typed rows expect exactly one token end of type ttype
  typedef struct packed {
    logic [7:0]    c;
    logic          eot;
    logic          typed;
    stt_pkg::tok_t ttype;
  } dir_row_t;

  localparam int NumRows = 25;
  localparam dir_row_t [0:NumRows-1] DirRows = '{
    '{stt_pkg::CharSemi,  1'b0, 1'b1, stt_pkg::TokSemi},   // punctuation right after reset
    '{"f",                1'b0, 1'b0, stt_pkg::TokNone},
    '{"o",                1'b0, 1'b0, stt_pkg::TokNone},
    '{"r",                1'b0, 1'b0, stt_pkg::TokNone},
    '{stt_pkg::CharSpace, 1'b0, 1'b1, stt_pkg::TokKwBase}, // "for" closed by whitespace
    '{"w",                1'b0, 1'b0, stt_pkg::TokNone},
    '{"h",                1'b0, 1'b0, stt_pkg::TokNone},
    '{"i",                1'b0, 1'b0, stt_pkg::TokNone},
    '{"l",                1'b0, 1'b0, stt_pkg::TokNone},
    '{"e",                1'b1, 1'b0, stt_pkg::TokNone},   // full hold depth, end flag
    '{stt_pkg::CharPlus,  1'b0, 1'b0, stt_pkg::TokNone},
    '{stt_pkg::CharEq,    1'b0, 1'b1, stt_pkg::TokPlusEq},
    '{stt_pkg::CharLt,    1'b0, 1'b0, stt_pkg::TokNone},
    '{stt_pkg::CharMinus, 1'b0, 1'b1, stt_pkg::TokLArrow},
    '{stt_pkg::CharMinus, 1'b0, 1'b0, stt_pkg::TokNone},
    '{"e",                1'b0, 1'b0, stt_pkg::TokNone},   // letter after operator
    '{8'h00,              1'b0, 1'b0, stt_pkg::TokNone},   // breaks keyword prefix, byte zero
    '{stt_pkg::CharQuote, 1'b0, 1'b0, stt_pkg::TokNone},   // quote closes word
    '{stt_pkg::CharTab,   1'b0, 1'b0, stt_pkg::TokNone},   // whitespace inside string
    '{8'hFF,              1'b1, 1'b0, stt_pkg::TokNone},   // unterminated string
    '{8'hFF,              1'b0, 1'b0, stt_pkg::TokNone},   // high byte as word char
    '{stt_pkg::CharCr,    1'b0, 1'b1, stt_pkg::TokWord},
    '{stt_pkg::CharEq,    1'b0, 1'b0, stt_pkg::TokNone},
    '{stt_pkg::CharEq,    1'b0, 1'b1, stt_pkg::TokEqEq},
    '{stt_pkg::CharGt,    1'b1, 1'b1, stt_pkg::TokGt}      // operator closed by end flag
  };

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] text_char = 8'h00;
  logic       end_flag  = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       result_kind_o;
  logic [5:0] token_type_o;
  logic [7:0] token_char_o;
  logic       last_of_run_o;

  source_text_tokenizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .text_char_i   (text_char),
    .end_of_text_i (end_flag),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .result_kind_o (result_kind_o),
    .token_type_o  (token_type_o),
    .token_char_o  (token_char_o),
    .last_of_run_o (last_of_run_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Lexer state of the predictor
  stt_pkg::tok_t lex_kind = stt_pkg::TokNone;
  logic [7:0]    held_chars [HoldDepth];
  int            held_n   = 0;
  logic [3:0]    kw_live  = 4'h0;

  tok_res_t step_tokens [$];
  tok_res_t tokens_due [$];
  int       fails      = 0;
  int       burst_left = 0;

  function automatic void emit(logic kind, stt_pkg::tok_t t, logic [7:0] c);
    tok_res_t r;
    r = '{kind, t, c, 1'b0};
    if (step_tokens.size() < stt_pkg::MaxResults) step_tokens.push_back(r);
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_n && i < HoldDepth; i++) begin
      emit(stt_pkg::ResText, stt_pkg::TokWord, held_chars[i]);
    end
    held_n = 0;
  endfunction

  function automatic void close_open();
    int kw;
    kw = 4;
    if (lex_kind == stt_pkg::TokNone) return;
    if (lex_kind == stt_pkg::TokWord) begin
      for (int k = 0; k < 4; k++)
        if (kw_live[k] && held_n == int'(KwLen[k])) kw = k;
      if (kw < 4) begin
        emit(stt_pkg::ResEnd, stt_pkg::tok_t'(stt_pkg::TokKwBase + kw), 8'h00);
      end else begin
        flush_held();
        emit(stt_pkg::ResEnd, stt_pkg::TokWord, 8'h00);
      end
    end else begin
      emit(stt_pkg::ResEnd, lex_kind, 8'h00);
    end
    lex_kind = stt_pkg::TokNone;
    held_n   = 0;
    kw_live  = 4'h0;
  endfunction

  // Hold the prefix while some keyword still matches, else stream it out
  function automatic void word_char(logic [7:0] c);
    logic [3:0] nm;
    nm = 4'h0;
    if (kw_live == 4'h0) begin
      emit(stt_pkg::ResText, stt_pkg::TokWord, c);
      return;
    end
    for (int k = 0; k < 4; k++)
      if (kw_live[k] && held_n < int'(KwLen[k]) && KwText[k][39-8*held_n -: 8] == c) nm[k] = 1'b1;
    if (nm != 4'h0 && held_n < HoldDepth) begin
      held_chars[held_n] = c;
      held_n++;
      kw_live = nm;
    end else begin
      flush_held();
      emit(stt_pkg::ResText, stt_pkg::TokWord, c);
      kw_live = 4'h0;
    end
  endfunction

  function automatic void start_single(stt_pkg::tok_t t);
    close_open();
    lex_kind = t;
  endfunction

  function automatic void pair_done(stt_pkg::tok_t t);
    emit(stt_pkg::ResEnd, t, 8'h00);
    lex_kind = stt_pkg::TokNone;
  endfunction

  function automatic void lone_punct(stt_pkg::tok_t t);
    close_open();
    emit(stt_pkg::ResEnd, t, 8'h00);
  endfunction

  // Results caused by one character transaction, left in step_tokens
  function automatic void lex_char(logic [7:0] c, logic e);
    step_tokens.delete();
    if (c == stt_pkg::CharQuote) begin
      if (lex_kind != stt_pkg::TokString) begin
        close_open();
        lex_kind = stt_pkg::TokString;
        emit(stt_pkg::ResText, stt_pkg::TokString, c);
      end else begin
        emit(stt_pkg::ResText, stt_pkg::TokString, c);
        close_open();
      end
    end else if (lex_kind == stt_pkg::TokString) begin
      emit(stt_pkg::ResText, stt_pkg::TokString, c);
    end else if (c == stt_pkg::CharSpace || (c >= stt_pkg::CharTab && c <= stt_pkg::CharCr)) begin
      close_open();
    end else begin
      case (c)
        stt_pkg::CharEq: begin
          case (lex_kind)
            stt_pkg::TokPlus:  pair_done(stt_pkg::TokPlusEq);
            stt_pkg::TokMinus: pair_done(stt_pkg::TokMinusEq);
            stt_pkg::TokStar:  pair_done(stt_pkg::TokStarEq);
            stt_pkg::TokSlash: pair_done(stt_pkg::TokSlashEq);
            stt_pkg::TokEqual: pair_done(stt_pkg::TokEqEq);
            stt_pkg::TokExcl:  pair_done(stt_pkg::TokNotEq);
            stt_pkg::TokLt:    pair_done(stt_pkg::TokLe);
            stt_pkg::TokGt:    pair_done(stt_pkg::TokGe);
            default:           start_single(stt_pkg::TokEqual);
          endcase
        end
        stt_pkg::CharPlus: begin
          if (lex_kind == stt_pkg::TokPlus) pair_done(stt_pkg::TokIncr);
          else start_single(stt_pkg::TokPlus);
        end
        stt_pkg::CharMinus: begin
          if (lex_kind == stt_pkg::TokMinus) pair_done(stt_pkg::TokDecr);
          else if (lex_kind == stt_pkg::TokLt) pair_done(stt_pkg::TokLArrow);
          else start_single(stt_pkg::TokMinus);
        end
        stt_pkg::CharGt: begin
          if (lex_kind == stt_pkg::TokMinus) pair_done(stt_pkg::TokRArrow);
          else start_single(stt_pkg::TokGt);
        end
        stt_pkg::CharStar:   start_single(stt_pkg::TokStar);
        stt_pkg::CharSlash:  start_single(stt_pkg::TokSlash);
        stt_pkg::CharExcl:   start_single(stt_pkg::TokExcl);
        stt_pkg::CharLt:     start_single(stt_pkg::TokLt);
        stt_pkg::CharSemi:   lone_punct(stt_pkg::TokSemi);
        stt_pkg::CharLBrace: lone_punct(stt_pkg::TokLBrace);
        stt_pkg::CharRBrace: lone_punct(stt_pkg::TokRBrace);
        stt_pkg::CharLParen: lone_punct(stt_pkg::TokLParen);
        stt_pkg::CharRParen: lone_punct(stt_pkg::TokRParen);
        stt_pkg::CharDot:    lone_punct(stt_pkg::TokDot);
        stt_pkg::CharComma:  lone_punct(stt_pkg::TokComma);
        default: begin
          if (lex_kind == stt_pkg::TokWord) begin
            word_char(c);
          end else begin
            close_open();
            lex_kind = stt_pkg::TokWord;
            held_n   = 0;
            kw_live  = 4'hF;
            word_char(c);
          end
        end
      endcase
    end
    if (e) close_open();
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
  endfunction

  // Offer one character, wait for the transaction, queue what it causes
  task automatic put_char(input logic [7:0] c, input logic e, input logic typed,
                          input stt_pkg::tok_t t);
    tok_res_t r;
    in_valid  <= 1'b1;
    text_char <= c;
    end_flag  <= e;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    lex_char(c, e);
    if (typed) begin
      r = '{stt_pkg::ResEnd, t, 8'h00, 1'b1};
      tokens_due.push_back(r);
    end else begin
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
    end
  endtask

  // Sender bursts and gaps; optionally hold off until everything has drained
  task automatic pace(input bit drain);
    if (drain) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while (tokens_due.size() != 0) @(posedge clk_i);
    end else if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end else begin
      burst_left--;
    end
  endtask

  // Receiver stall pattern: modes of random length
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((stall_tick % 7) >= 4);
    endcase
  end

  always @(posedge clk_i) begin
    tok_res_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall) begin
      if (tokens_due.size() == 0) begin
        $error("unexpected result: kind %0d type %0d char %02h", result_kind_o, token_type_o,
               token_char_o);
        fails++;
      end else begin
        want = tokens_due.pop_front();
        if (result_kind_o !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind_o);
          fails++;
        end
        if (token_type_o !== want.ttype) begin
          $error("token_type: expected %0d, got %0d", want.ttype, token_type_o);
          fails++;
        end
        if (token_char_o !== want.ch) begin
          $error("token_char: expected %02h, got %02h", want.ch, token_char_o);
          fails++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run_o);
          fails++;
        end
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("source_text_tokenizer regression: fail");
    $finish;
  end

  initial begin
    logic [8:0] src_q [$];
    string      kw;
    logic [7:0] b;
    int         n;
    int         k;
    int         pick;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      put_char(DirRows[r].c, DirRows[r].eot, DirRows[r].typed, DirRows[r].ttype);
      pace(1'b0);
    end

    // Mostly well-formed tokens with random content, some noise bytes
    while (src_q.size() < NumRandom) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        case ($urandom_range(0, 3))
          0:       kw = "for";
          1:       kw = "while";
          2:       kw = "if";
          default: kw = "else";
        endcase
        n = kw.len();
        k = $urandom_range(0, 3);
        if (k == 1) n = n - 1;
        for (int j = 0; j < n; j++) begin
          b = kw[j];
          if (k == 3 && j == n - 1) b = 8'($urandom_range(8'h61, 8'h7a));
          src_q.push_back({1'b0, b});
        end
        if (k == 2) src_q.push_back({1'b0, 8'($urandom_range(8'h61, 8'h7a))});
      end else if (pick < 40) begin
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++) begin
          case ($urandom_range(0, 4))
            0, 1: b = 8'($urandom_range(8'h61, 8'h7a));
            2: b = $urandom_range(0, 1) ? 8'($urandom_range(8'h30, 8'h39))
                                        : 8'($urandom_range(8'h41, 8'h5a));
            3: b = 8'($urandom_range(128, 255));
            default: begin
              b = 8'($urandom_range(0, 26));
              if (b >= 8'd9) b = b + 8'd5;   // control bytes outside whitespace
            end
          endcase
          src_q.push_back({1'b0, b});
        end
      end else if (pick < 52) begin
        src_q.push_back({1'b0, stt_pkg::CharQuote});
        n = $urandom_range(0, 6);
        for (int j = 0; j < n; j++) begin
          b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(32, 126));
          src_q.push_back({1'b0, b});
        end
        if ($urandom_range(0, 4) != 0) src_q.push_back({1'b0, stt_pkg::CharQuote});
      end else if (pick < 72) begin
        k = $urandom_range(0, 7);
        src_q.push_back({1'b0, OpFirst[8*k +: 8]});
        if ($urandom_range(0, 1) == 1) begin
          k = $urandom_range(0, 3);
          src_q.push_back({1'b0, OpSecond[8*k +: 8]});
        end
      end else if (pick < 82) begin
        k = $urandom_range(0, 6);
        src_q.push_back({1'b0, PunctSet[8*k +: 8]});
      end else begin
        src_q.push_back({1'b0, 8'($urandom_range(0, 255))});
      end
      if ($urandom_range(0, 19) == 0) src_q[src_q.size()-1][8] = 1'b1;
      if ($urandom_range(0, 1) == 1) begin
        k = $urandom_range(0, 5);
        src_q.push_back({1'b0, SpaceSet[8*k +: 8]});
      end
    end

    foreach (src_q[i]) begin
      put_char(src_q[i][7:0], src_q[i][8], 1'b0, stt_pkg::TokNone);
      pace(i == src_q.size() / 2);
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("source_text_tokenizer regression: pass");
    end else begin
      $display("source_text_tokenizer regression: fail");
    end
    $finish;
  end

endmodule
